// File: hdl/vwalu_pkg.sv
// Package: request/response types, operation codes and sizes for the variable width ALU.
`default_nettype none
package vwalu_pkg;

   localparam int unsigned DATA_W = 64;
   localparam int unsigned OPW_W  = 7;
   localparam int unsigned CODE_W = 5;
   localparam int unsigned SHAMT_W = 6;

   typedef enum logic [CODE_W-1:0] {
      OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_AND  = 5'd3,
      OP_OR   = 5'd4,  OP_XOR  = 5'd5,  OP_SHL  = 5'd6,  OP_LSHR = 5'd7,
      OP_ASHR = 5'd8,  OP_UDIV = 5'd9,  OP_UREM = 5'd10, OP_SDIV = 5'd11,
      OP_SREM = 5'd12, OP_EQ   = 5'd13, OP_NE   = 5'd14, OP_SLT  = 5'd15,
      OP_SLE  = 5'd16, OP_SGT  = 5'd17, OP_SGE  = 5'd18, OP_ULT  = 5'd19,
      OP_ULE  = 5'd20, OP_UGT  = 5'd21, OP_UGE  = 5'd22
   } op_type;

   typedef struct packed {
      logic [CODE_W-1:0] req_type;
      logic [OPW_W-1:0]  operand_width;
      logic [DATA_W-1:0] lhs_bits;
      logic [DATA_W-1:0] rhs_bits;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_bits;
      logic              result_valid;
   } rsp_type;

   // operation travelling along the divider chain
   typedef struct packed {
      logic              vld;
      logic              is_div;   // divide result, else remainder or other result
      logic              neg_q;
      logic              neg_r;
      logic              ok;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] other;    // precomputed non-divide result
   } ctl_type;

endpackage
`default_nettype wire

// File: hdl/vwalu_cell.sv
// One restoring divide cell: retires one quotient bit per cycle and hands the row on.
`default_nettype none
module vwalu_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire vwalu_pkg::ctl_type          ctl_in,
   input  wire logic [vwalu_pkg::DATA_W-1:0] rem_in,
   input  wire logic [vwalu_pkg::DATA_W-1:0] quo_in,
   input  wire logic [vwalu_pkg::DATA_W-1:0] dvs_in,
   output vwalu_pkg::ctl_type               ctl_out,
   output logic [vwalu_pkg::DATA_W-1:0]      rem_out,
   output logic [vwalu_pkg::DATA_W-1:0]      quo_out,
   output logic [vwalu_pkg::DATA_W-1:0]      dvs_out
);
   logic [vwalu_pkg::DATA_W:0]   trial;
   logic [vwalu_pkg::DATA_W:0]   diff;
   logic [vwalu_pkg::DATA_W-1:0] rem_in_w;
   logic [vwalu_pkg::DATA_W-1:0] quo_in_w;
   logic                         vld_ff;
   vwalu_pkg::ctl_type           ctl_ff;
   logic [vwalu_pkg::DATA_W-1:0] rem_ff, quo_ff, dvs_ff;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      trial    = {rem_in, quo_in[vwalu_pkg::DATA_W-1]};
      diff     = trial - {1'b0, dvs_in};
      quo_in_w = {quo_in[vwalu_pkg::DATA_W-2:0], ~diff[vwalu_pkg::DATA_W]};
      rem_in_w = diff[vwalu_pkg::DATA_W] ? trial[vwalu_pkg::DATA_W-1:0]
                                         : diff[vwalu_pkg::DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= ctl_in.vld;
      end
      ctl_ff <= ctl_in;
      rem_ff <= rem_in_w;
      quo_ff <= quo_in_w;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      ctl_out     = ctl_ff;
      ctl_out.vld = vld_ff;
   end
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
   assign dvs_out = dvs_ff;
endmodule
`default_nettype wire

// File: hdl/vwalu_front.sv
// Front stage: masking, sign handling and all non-divide operations; multiply is split in parts.
`default_nettype none
module vwalu_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_vld,
   input  wire vwalu_pkg::req_type          req,
   output vwalu_pkg::ctl_type               ctl_out,
   output logic [vwalu_pkg::DATA_W-1:0]      dvd_out,
   output logic [vwalu_pkg::DATA_W-1:0]      dvs_out
);
   localparam int unsigned W = vwalu_pkg::DATA_W;
   localparam int unsigned H = W / 2;

   logic [vwalu_pkg::OPW_W-1:0] w;
   logic            zero_w;
   logic [W-1:0]    m, a, b, sa, sb, sbit, ma, mb, r;
   logic            ok, nega, negb, b_big, is_div, is_dop, ovf;
   logic [W-1:0]    shl_r, lshr_r, ashr_r;
   logic [vwalu_pkg::SHAMT_W-1:0] sh;

   // stage one registers
   logic            vld_ff;
   vwalu_pkg::ctl_type ctl_ff;
   logic [W-1:0]    dvd_ff, dvs_ff;
   logic            mul_ff;
   logic [W-1:0]    pll_ff, plh_ff, phl_ff;

   always_comb begin
      w      = (req.operand_width > vwalu_pkg::OPW_W'(W)) ? vwalu_pkg::OPW_W'(W)
                                                         : req.operand_width;
      zero_w = (w == '0);
      m      = (w >= vwalu_pkg::OPW_W'(W)) ? '1 : ((W'(1) << w) - W'(1));
      a      = req.lhs_bits & m;
      b      = req.rhs_bits & m;
      sbit   = zero_w ? '0 : (W'(1) << (w - vwalu_pkg::OPW_W'(1)));
      sa     = (a ^ sbit) - sbit;
      sb     = (b ^ sbit) - sbit;
      nega   = sa[W-1];
      negb   = sb[W-1];
      ma     = nega ? (W'(0) - sa) : sa;
      mb     = negb ? (W'(0) - sb) : sb;
      b_big  = (b >= W'(w));
      sh     = b[vwalu_pkg::SHAMT_W-1:0];
      shl_r  = a << sh;
      lshr_r = a >> sh;
      ashr_r = W'($signed(sa) >>> sh);
      // minimum signed value divided by minus one
      ovf    = (sa == (W'(0) - sbit)) && (sb == '1);
      ok     = 1'b1;
      r      = '0;
      is_div = 1'b0;
      is_dop = 1'b0;
      case (req.req_type)
         vwalu_pkg::OP_ADD:  r = a + b;
         vwalu_pkg::OP_SUB:  r = a - b;
         vwalu_pkg::OP_MUL:  r = '0;
         vwalu_pkg::OP_AND:  r = a & b;
         vwalu_pkg::OP_OR:   r = a | b;
         vwalu_pkg::OP_XOR:  r = a ^ b;
         vwalu_pkg::OP_SHL:  begin ok = !b_big; r = shl_r;  end
         vwalu_pkg::OP_LSHR: begin ok = !b_big; r = lshr_r; end
         vwalu_pkg::OP_ASHR: begin ok = !b_big; r = ashr_r; end
         vwalu_pkg::OP_UDIV: begin ok = (b != '0); is_dop = 1'b1; is_div = 1'b1; end
         vwalu_pkg::OP_UREM: begin ok = (b != '0); is_dop = 1'b1; end
         vwalu_pkg::OP_SDIV: begin
            ok = (b != '0) && !ovf;
            is_dop = 1'b1; is_div = 1'b1;
         end
         vwalu_pkg::OP_SREM: begin
            ok = (b != '0) && !ovf;
            is_dop = 1'b1;
         end
         vwalu_pkg::OP_EQ:   r = W'(a == b);
         vwalu_pkg::OP_NE:   r = W'(a != b);
         vwalu_pkg::OP_SLT:  r = W'($signed(sa) <  $signed(sb));
         vwalu_pkg::OP_SLE:  r = W'($signed(sa) <= $signed(sb));
         vwalu_pkg::OP_SGT:  r = W'($signed(sa) >  $signed(sb));
         vwalu_pkg::OP_SGE:  r = W'($signed(sa) >= $signed(sb));
         vwalu_pkg::OP_ULT:  r = W'(a <  b);
         vwalu_pkg::OP_ULE:  r = W'(a <= b);
         vwalu_pkg::OP_UGT:  r = W'(a >  b);
         vwalu_pkg::OP_UGE:  r = W'(a >= b);
         default:            ok = 1'b0;
      endcase
      if (zero_w) ok = 1'b0;
   end

   // register stage one: operands, partial products, flags
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
      ctl_ff.vld    <= in_vld;
      ctl_ff.is_div <= is_div;
      ctl_ff.ok     <= ok;
      ctl_ff.mask   <= m;
      ctl_ff.other  <= r;
      ctl_ff.neg_q  <= (req.req_type == vwalu_pkg::OP_SDIV) && (nega != negb);
      ctl_ff.neg_r  <= (req.req_type == vwalu_pkg::OP_SREM) && nega;
      mul_ff        <= (req.req_type == vwalu_pkg::OP_MUL);
      dvd_ff        <= (req.req_type == vwalu_pkg::OP_SDIV ||
                        req.req_type == vwalu_pkg::OP_SREM) ? ma : a;
      dvs_ff        <= (req.req_type == vwalu_pkg::OP_SDIV ||
                        req.req_type == vwalu_pkg::OP_SREM) ? mb :
                       (is_dop ? b : W'(1));
      pll_ff        <= a[H-1:0] * b[H-1:0];
      plh_ff        <= W'(a[H-1:0] * b[W-1:H]);
      phl_ff        <= W'(a[W-1:H] * b[H-1:0]);
   end

   // combine multiply parts; non-divide results ride through the chain in other, beside a divide by one
   always_comb begin
      ctl_out       = ctl_ff;
      ctl_out.vld   = vld_ff;
      if (mul_ff) begin
         ctl_out.other = pll_ff + {plh_ff[H-1:0] + phl_ff[H-1:0], {H{1'b0}}};
      end
   end
   assign dvd_out = dvd_ff;
   assign dvs_out = dvs_ff;
endmodule
`default_nettype wire

// File: hdl/variable_width_integer_alu.sv
// Top level: variable width integer ALU built as a front stage and a chain of divide cells.
//
// Usage: drive req with an operation code, an operand width and two operands and
// pulse start. busy is always low, so one request is taken in every cycle.
// Every request yields exactly one response on rsp, marked by done for one cycle.
// Every operation takes the same path (front stage, 64 divide cells,
// output register); throughput is one request per cycle. The length of the divide
// cell chain, one quotient bit per cell, sets the latency.
// Results from operations other than divide and remainder ride along the chain
// unchanged so all responses leave in request order.
// Invalid operations give result_valid low and result_bits zero.
// Synchronous reset empties the pipeline; nothing in flight is reported.
// The receiver cannot stall: done is a strobe and must be taken.
`default_nettype none
module variable_width_integer_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire vwalu_pkg::req_type req_data,
   output logic                    done,
   output vwalu_pkg::rsp_type      rsp_data
);
   localparam int unsigned W = vwalu_pkg::DATA_W;

   vwalu_pkg::ctl_type   ctl [W+1];
   logic [W-1:0]         rem [W+1];
   logic [W-1:0]         quo [W+1];
   logic [W-1:0]         dvs [W+1];
   logic [W-1:0]         res;
   logic                 done_ff;
   vwalu_pkg::rsp_type   rsp_ff;

   assign busy = 1'b0;

   vwalu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start),
      .req     (req_data),
      .ctl_out (ctl[0]),
      .dvd_out (quo[0]),
      .dvs_out (dvs[0])
   );
   assign rem[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      vwalu_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (ctl[i]),
         .rem_in  (rem[i]),
         .quo_in  (quo[i]),
         .dvs_in  (dvs[i]),
         .ctl_out (ctl[i+1]),
         .rem_out (rem[i+1]),
         .quo_out (quo[i+1]),
         .dvs_out (dvs[i+1])
      );
   end

   // pick and fix sign of the final result
   always_comb begin
      res = ctl[W].other;
      if (ctl[W].is_div) res = ctl[W].neg_q ? (W'(0) - quo[W]) : quo[W];
      else if (dvs[W] != W'(1) || ctl[W].neg_r) res = ctl[W].neg_r ? (W'(0) - rem[W]) : rem[W];
   end

   // register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= ctl[W].vld;
      end
      rsp_ff.result_bits  <= ctl[W].ok ? (res & ctl[W].mask) : '0;
      rsp_ff.result_valid <= ctl[W].ok;
   end

   assign done     = done_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// File: hdl/vwalu_checker.sv
// Port-level checker for the variable width ALU, bound to the top level.
`default_nettype none
module vwalu_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               done,
   input wire vwalu_pkg::rsp_type rsp_data
);
   localparam int unsigned LAT = vwalu_pkg::DATA_W + 2;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      done && !rsp_data.result_valid |-> rsp_data.result_bits == '0)
      else $error("invalid response carries data");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT done)
      else $error("response missing");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(start, LAT))
      else $error("response without request");
endmodule

bind variable_width_integer_alu vwalu_checker u_vwalu_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .done     (done),
   .rsp_data (rsp_data)
);
`default_nettype wire

// File: tb/variable_width_integer_alu_tb.sv
// Testbench for the variable width integer ALU: directed and random requests checked against a predictor.
`default_nettype none
module variable_width_integer_alu_tb;

   localparam int unsigned LATENCY   = vwalu_pkg::DATA_W + 2;
   localparam int unsigned N_RANDOM  = 618;
   localparam int unsigned MAX_CYCLE = 200000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   vwalu_pkg::req_type req_data;
   logic    done;
   vwalu_pkg::rsp_type rsp_data;

   vwalu_pkg::req_type pending_reqs[$];
   vwalu_pkg::rsp_type expected_rsps[$];
   int      n_errors = 0;
   int      cycle_count = 0;
   bit      stim_done;
   bit      hold_for_drain;
   int      burst_left;
   int      gap_left;

   variable_width_integer_alu DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .done     (done),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Compute the folded result of one request.
   function automatic vwalu_pkg::rsp_type alu_fold(vwalu_pkg::req_type r);
      vwalu_pkg::rsp_type o;
      int unsigned w;
      logic [63:0] m, a, b, sa, sb, x, ma, mb, smin;
      logic        ok;
      w = r.operand_width;
      if (w > 64) w = 64;
      o = '0;
      if (w == 0 || r.req_type > vwalu_pkg::OP_UGE) return o;
      m  = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
      a  = r.lhs_bits & m;
      b  = r.rhs_bits & m;
      sa = (w == 64) ? a : ((a ^ (64'd1 << (w - 1))) - (64'd1 << (w - 1)));
      sb = (w == 64) ? b : ((b ^ (64'd1 << (w - 1))) - (64'd1 << (w - 1)));
      smin = ~64'd0 << (w - 1);
      ok = 1'b1;
      x  = '0;
      case (vwalu_pkg::op_type'(r.req_type))
         vwalu_pkg::OP_ADD:  x = a + b;
         vwalu_pkg::OP_SUB:  x = a - b;
         vwalu_pkg::OP_MUL:  x = a * b;
         vwalu_pkg::OP_AND:  x = a & b;
         vwalu_pkg::OP_OR:   x = a | b;
         vwalu_pkg::OP_XOR:  x = a ^ b;
         vwalu_pkg::OP_SHL:  if (b >= w) ok = 0; else x = a << b;
         vwalu_pkg::OP_LSHR: if (b >= w) ok = 0; else x = a >> b;
         vwalu_pkg::OP_ASHR: if (b >= w) ok = 0; else x = $signed(sa) >>> b;
         vwalu_pkg::OP_UDIV: if (b == 0) ok = 0; else x = a / b;
         vwalu_pkg::OP_UREM: if (b == 0) ok = 0; else x = a % b;
         vwalu_pkg::OP_SDIV, vwalu_pkg::OP_SREM: begin
            if (b == 0 || (sa == smin && sb == '1)) begin
               ok = 0;
            end else begin
               ma = sa[63] ? -sa : sa;
               mb = sb[63] ? -sb : sb;
               if (r.req_type == vwalu_pkg::OP_SDIV) begin
                  x = ma / mb;
                  if (sa[63] != sb[63]) x = -x;
               end else begin
                  x = ma % mb;
                  if (sa[63]) x = -x;
               end
            end
         end
         vwalu_pkg::OP_EQ:  x = 64'(a == b);
         vwalu_pkg::OP_NE:  x = 64'(a != b);
         vwalu_pkg::OP_SLT: x = 64'($signed(sa) < $signed(sb));
         vwalu_pkg::OP_SLE: x = 64'($signed(sa) <= $signed(sb));
         vwalu_pkg::OP_SGT: x = 64'($signed(sa) > $signed(sb));
         vwalu_pkg::OP_SGE: x = 64'($signed(sa) >= $signed(sb));
         vwalu_pkg::OP_ULT: x = 64'(a < b);
         vwalu_pkg::OP_ULE: x = 64'(a <= b);
         vwalu_pkg::OP_UGT: x = 64'(a > b);
         default: x = 64'(a >= b);
      endcase
      o.result_valid = ok;
      o.result_bits  = ok ? (x & m) : '0;
      return o;
   endfunction

   // Pick an operand value biased toward the edges of the width.
   function automatic logic [63:0] pick_operand(int unsigned w);
      logic [63:0] m, v;
      m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = m;
         2: v = (w == 0) ? '0 : (64'd1 << (w - 1));
         3: v = 64'd1;
         4: v = m & ~(64'd1 << ((w == 0) ? 0 : w - 1));
         5: v = 64'($urandom_range(0, 70));
         default: v = {$urandom, $urandom} & m;
      endcase
      // occasionally leave garbage above the width
      if ($urandom_range(0, 9) == 0) v = {$urandom, $urandom};
      return v;
   endfunction

   task automatic queue_req(int unsigned code, int unsigned w, logic [63:0] a, logic [63:0] b);
      vwalu_pkg::req_type r;
      r.req_type      = code[vwalu_pkg::CODE_W-1:0];
      r.operand_width = w[vwalu_pkg::OPW_W-1:0];
      r.lhs_bits      = a;
      r.rhs_bits      = b;
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      n_errors++;
   endtask

   // Fill the request queue: directed cases, then random ones.
   initial begin
      int unsigned code, w;
      for (int i = vwalu_pkg::OP_ADD; i <= vwalu_pkg::OP_UGE; i++)
         queue_req(i, 64, 64'h8000_0000_0000_0000, '1);
      queue_req(vwalu_pkg::OP_SHL, 8, 8'h5a, 8);
      queue_req(vwalu_pkg::OP_ASHR, 8, 8'h80, 7);
      queue_req(vwalu_pkg::OP_UDIV, 16, 16'h1234, 0);
      queue_req(vwalu_pkg::OP_SREM, 1, 1, 1);
      queue_req(vwalu_pkg::OP_SDIV, 32, 32'h8000_0000, 32'hffff_ffff);
      queue_req(31, 64, '1, '1);
      queue_req(vwalu_pkg::OP_ADD, 0, '1, '1);
      queue_req(vwalu_pkg::OP_MUL, 127, '1, '1);
      queue_req(vwalu_pkg::OP_XOR, 4, '1, 64'h0);
      for (int i = 0; i < N_RANDOM; i++) begin
         code = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 22);
         case ($urandom_range(0, 9))
            0: w = 64;
            1: w = 1;
            2: w = $urandom_range(0, 127);
            default: w = $urandom_range(1, 64);
         endcase
         queue_req(code, w, pick_operand(w),
                   (code >= vwalu_pkg::OP_SHL && code <= vwalu_pkg::OP_ASHR &&
                    $urandom_range(0, 2) != 0)
                      ? 64'($urandom_range(0, (w > 64) ? 64 : w)) : pick_operand(w));
         if (i == N_RANDOM / 2) queue_req(32'hffff_ffff, 32'hffff_ffff, '1, '1);
      end
   end

   // Drive requests in bursts; drain once halfway through.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         burst_left <= 0;
         gap_left <= 0;
         hold_for_drain <= 1'b0;
         stim_done <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps = {expected_rsps, alu_fold(req_data)};
            pending_reqs.pop_front();
         end
         if (hold_for_drain && expected_rsps.size() == 0 && !(start && !busy)) begin
            hold_for_drain <= 1'b0;
         end
         if (pending_reqs.size() == 320 && !hold_for_drain && start && !busy) begin
            hold_for_drain <= 1'b1;
            start <= 1'b0;
         end else if (hold_for_drain) begin
            start <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (start && busy) begin
            start <= 1'b1;
         end else begin
            if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs[0];
               start <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 30);
                  if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(0, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
               stim_done <= 1'b1;
            end
         end
      end
   end

   // Compare each response with the oldest expectation.
   always @(posedge clock) begin
      vwalu_pkg::rsp_type want;
      if (!reset && done) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.result_bits, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.result_valid !== want.result_valid)
               report_mismatch("result_valid", 64'(rsp_data.result_valid),
                               64'(want.result_valid));
            if (rsp_data.result_bits !== want.result_bits)
               report_mismatch("result_bits", rsp_data.result_bits, want.result_bits);
         end
      end
   end

   // Reset, wait for the drain, then decide.
   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_rsps.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("PASS variable_width_integer_alu");
      end else begin
         $display("FAIL variable_width_integer_alu");
      end
      $finish;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLE) begin
         $display("FAIL variable_width_integer_alu");
         $finish;
      end
   end

endmodule
`default_nettype wire
